// ----- rtl/mbrf_pkg.sv -----
// Shared types, constants and helpers for the multi-byte ring FIFO.
package mbrf_pkg;

    // Ring size and lane count
    localparam int DEPTH     = 256;
    localparam int LANES     = 4;
    // Byte fields carried by one item; also the number of storage banks
    localparam int NUM_BYTES = 4;
    localparam int USE_LANES = (LANES < NUM_BYTES) ? LANES : NUM_BYTES;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int BANK_W    = $clog2(NUM_BYTES);
    localparam int ROW_W     = PTR_W - BANK_W;
    localparam int ROWS      = DEPTH / NUM_BYTES;
    localparam int CNT_W     = 3;
    localparam int FILL_W    = 8;

    typedef logic [7:0]       byte_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request kinds
    typedef enum logic [1:0] {
        OP_WR   = 2'd0,
        OP_RD   = 2'd1,
        OP_CLR  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Per-bank access for one item
    typedef struct packed {
        logic  we;
        row_t  wrow;
        byte_t wdata;
        logic  re;
        row_t  rrow;
    } lane_req_t;

    // Fill level clipped to the result field
    function automatic logic [FILL_W-1:0] sat_fill(input ptr_t fill);
        logic [FILL_W-1:0] res;
        if (PTR_W > FILL_W) begin
            res = (fill > ptr_t'({FILL_W{1'b1}})) ? {FILL_W{1'b1}} : fill[FILL_W-1:0];
        end else begin
            res = FILL_W'(fill);
        end
        return res;
    endfunction

endpackage

// ----- rtl/multi_byte_ring_fifo.sv -----
// Top level of the multi-byte ring FIFO: pointers, bank control and result registers.
//
// Usage: raise start with op, count and in_byte0..3; the item is taken at a
// clock edge where start is high and busy is low. op selects write (store
// count bytes, taken whole or refused whole), read (return up to count of the
// oldest bytes) or clear (empty the ring). The ring holds DEPTH-1 bytes.
// In the cycle after the item is taken, done pulses for exactly one cycle with
// accepted, read_count, out_byte0..3 (oldest first, zero past read_count)
// and fill_level. The receiver cannot hold results off; none are lost since
// one result register is loaded per item and read out the next cycle.
// Throughput is one item per cycle while busy is low; results are registered,
// the read bytes in the registered read port of the storage banks. Storage is
// split into NUM_BYTES interleaved banks so the bytes of one item all land in
// different banks. Reset empties the ring (both pointers to zero) and holds
// busy high for one cycle after release; store contents are not cleared.
module multi_byte_ring_fifo
    import mbrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [2:0]  count,
    input  logic [7:0]  in_byte0,
    input  logic [7:0]  in_byte1,
    input  logic [7:0]  in_byte2,
    input  logic [7:0]  in_byte3,
    output logic        done,
    output logic        accepted,
    output logic [2:0]  read_count,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic [7:0]  fill_level
);

    ptr_t  head_reg, head_next;
    ptr_t  tail_reg, tail_next;
    logic  busy_reg;
    logic  done_reg;
    logic  accepted_reg, accepted_next;
    cnt_t  nread_reg, nread_next;
    bank_t rot_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;

    op_t   op_c;
    logic  take;
    ptr_t  fill, space, cnt_ext, want_ext;
    cnt_t  want;
    logic  wr_ok;
    logic  do_wr, do_rd;

    byte_t [NUM_BYTES-1:0] wbytes;
    byte_t [NUM_BYTES-1:0] bank_data;
    byte_t [NUM_BYTES-1:0] out_data;
    lane_req_t             lane_req [NUM_BYTES];

    assign wbytes = {in_byte3, in_byte2, in_byte1, in_byte0};
    assign op_c   = op_t'(op);
    assign take   = start && !busy_reg;

    // Pointer arithmetic and request decode
    always_comb
    begin
        fill     = head_reg - tail_reg;
        space    = ptr_t'(DEPTH - 1) - fill;
        cnt_ext  = ptr_t'(count);
        wr_ok    = (count == '0) ||
                   ((count <= cnt_t'(USE_LANES)) && (cnt_ext <= space));
        want     = (count > cnt_t'(USE_LANES)) ? cnt_t'(USE_LANES) : count;
        want_ext = ptr_t'(want);
        do_wr    = take && (op_c == OP_WR) && wr_ok;
        do_rd    = take && (op_c == OP_RD);

        nread_next    = '0;
        accepted_next = 1'b0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        case (op_c)
            OP_WR:
            begin
                accepted_next = wr_ok;
                if (do_wr)
                begin
                    head_next = head_reg + cnt_ext;
                end
            end
            OP_RD:
            begin
                accepted_next = 1'b1;
                nread_next    = (want_ext <= fill) ? want : cnt_t'(fill);
                if (take)
                begin
                    tail_next = tail_reg + ptr_t'(nread_next);
                end
            end
            OP_CLR:
            begin
                accepted_next = 1'b1;
                if (take)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase
        fill_next = sat_fill(head_next - tail_next);
    end

    // Per-bank access: bank b takes byte k where (head + k) lands in b, and reads byte k where (tail + k) lands in b
    for (genvar g = 0; g < NUM_BYTES; g++)
    begin : g_lane
        bank_t kw, kr;
        ptr_t  waddr, raddr;

        always_comb
        begin
            kw    = bank_t'(g) - head_reg[BANK_W-1:0];
            kr    = bank_t'(g) - tail_reg[BANK_W-1:0];
            waddr = head_reg + ptr_t'(kw);
            raddr = tail_reg + ptr_t'(kr);
            lane_req[g].we    = do_wr && (cnt_t'(kw) < count);
            lane_req[g].wrow  = waddr[PTR_W-1:BANK_W];
            lane_req[g].wdata = wbytes[kw];
            lane_req[g].re    = do_rd;
            lane_req[g].rrow  = raddr[PTR_W-1:BANK_W];
        end

        mbrf_lane u_lane (
            .clk   (clk),
            .req   (lane_req[g]),
            .rdata (bank_data[g])
        );
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            busy_reg <= 1'b0;
            done_reg <= take;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            accepted_reg <= accepted_next;
            nread_reg    <= nread_next;
            fill_reg     <= fill_next;
            rot_reg      <= tail_reg[BANK_W-1:0];
        end
    end

    mbrf_merge u_merge (
        .bank_data (bank_data),
        .rot       (rot_reg),
        .nread     (nread_reg),
        .out_data  (out_data)
    );

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign accepted   = accepted_reg;
    assign read_count = nread_reg;
    assign fill_level = fill_reg;
    assign out_byte0  = out_data[0];
    assign out_byte1  = out_data[1];
    assign out_byte2  = out_data[2];
    assign out_byte3  = out_data[3];

endmodule

// ----- rtl/mbrf_lane.sv -----
// One storage bank: holds every NUM_BYTES-th byte of the ring, one write and one read a cycle.
module mbrf_lane
    import mbrf_pkg::*;
(
    input  logic      clk,
    input  lane_req_t req,
    output byte_t     rdata
);

    byte_t mem [ROWS];
    byte_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wrow] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.rrow];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mbrf_merge.sv -----
// Merge stage: rotates bank read data into oldest-first order and blanks unused bytes.
module mbrf_merge
    import mbrf_pkg::*;
(
    input  byte_t [NUM_BYTES-1:0] bank_data,
    input  bank_t                 rot,
    input  cnt_t                  nread,
    output byte_t [NUM_BYTES-1:0] out_data
);

    // Byte k came from bank (rot + k)
    always_comb
    begin
        bank_t sel;
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            sel = rot + bank_t'(k);
            if (cnt_t'(k) < nread)
            begin
                out_data[k] = bank_data[sel];
            end else begin
                out_data[k] = '0;
            end
        end
    end

endmodule
